### rtl/symmetric_triangle_expand_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for symmetric_triangle_expand
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_TRIANGLE_EXPAND_ASSERT_SVH
`define SYMMETRIC_TRIANGLE_EXPAND_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define STE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("symmetric_triangle_expand: assertion failed");

// Next-cycle implication.
`define STE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("symmetric_triangle_expand: assertion failed");

`else

`define STE_ASSERT_IMP(lbl, ante, cons)
`define STE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Sizes, widths, status codes and result type of the triangle expander.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    localparam int MAX_DIM     = 256;
    localparam int MAX_TRI_NNZ = 1024;
    localparam int SQ_CAP      = 2 * MAX_TRI_NNZ;

    localparam int DIM_W  = 9;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 64;
    localparam int LC_W   = $clog2(MAX_TRI_NNZ + 1);
    localparam int TRI_AW = $clog2(MAX_TRI_NNZ);
    localparam int TCS_AW = $clog2(MAX_DIM + 1);
    localparam int CNT_AW = $clog2(MAX_DIM);
    localparam int POS_W  = $clog2(SQ_CAP);
    localparam int TRI_W  = 1 + IDX_W + VAL_W;
    localparam int SQ_W   = IDX_W + VAL_W;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 104;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_OVERFLOW,
        ST_EMPTY
    } status_t;

    typedef struct packed {
        logic [POS_W-1:0] col_start;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        status_t          status;
    } res_t;

endpackage

`default_nettype wire

### rtl/ste_ram.sv
// ----------------------------------------------------------------------------
// ste_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/symmetric_triangle_expand.sv
// ----------------------------------------------------------------------------
// symmetric_triangle_expand
// Lower-triangular sparse matrix in, full symmetric matrix out, column order.
// ----------------------------------------------------------------------------
// Send the lower triangle column by column, one nonzero per load request
// (tuser = 0), each column opening with its diagonal, and mark the final one
// with tlast. The request marked last starts a build if no error is found,
// during which s_tready is low: a clear pass over the count RAM, a count pass
// bumping the row count of each off-diagonal entry, a prefix pass of a read
// and a write per column and a closing step, and a scatter pass writing each
// entry into the square RAM, off-diagonal ones twice. Every pass is paced by
// the single read and write port of the count RAM, which holds the per-column
// mirror counts and later the fill pointers. Each fetch request (tuser = 1)
// then runs a square RAM read, a column step and a result hand-off and
// returns the next square entry; a fetch with nothing to give returns status
// only, without the read. Errors stick until the first load after tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_triangle_expand (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: dim
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ste_pkg::DIM_W-1:0]     cfg_data,
    // request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // column[7:0], row[15:8], in_value[79:16]
    input  wire logic [ste_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[0]
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_column[7:0], out_row[15:8], out_value[79:16], out_position[90:80],
    // column_start[101:91], zero[103:102]
    output logic [ste_pkg::M_DATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    localparam int DIM_W  = ste_pkg::DIM_W;
    localparam int IDX_W  = ste_pkg::IDX_W;
    localparam int VAL_W  = ste_pkg::VAL_W;
    localparam int LC_W   = ste_pkg::LC_W;
    localparam int TRI_AW = ste_pkg::TRI_AW;
    localparam int TCS_AW = ste_pkg::TCS_AW;
    localparam int CNT_AW = ste_pkg::CNT_AW;
    localparam int POS_W  = ste_pkg::POS_W;
    localparam int TRI_W  = ste_pkg::TRI_W;
    localparam int SQ_W   = ste_pkg::SQ_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_TRI,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_PFX_END,
        S_SC_RD,
        S_SC_TRI,
        S_SC_CNT,
        S_SC_OWN,
        S_F_RD,
        S_F_DATA,
        S_EMIT
    } state_t;

    state_t               state_reg;
    logic [DIM_W-1:0]     dim_reg;
    logic [DIM_W-1:0]     n_reg;
    logic [DIM_W-1:0]     built_dim_reg;
    ste_pkg::status_t     err_reg;
    logic                 ready_reg;
    logic [LC_W-1:0]      lc_reg;
    logic [IDX_W-1:0]     lastc_reg;
    logic [POS_W-1:0]     fp_reg;
    logic [POS_W-1:0]     sqc_reg;
    logic [IDX_W-1:0]     fc_reg;
    logic [POS_W-1:0]     cs_reg;
    logic [LC_W-1:0]      idx_reg;
    logic [POS_W-1:0]     acc_reg;
    logic [LC_W-1:0]      tcs_cur_reg;
    logic [IDX_W-1:0]     cur_col_reg;
    logic [IDX_W-1:0]     row_reg;
    logic [VAL_W-1:0]     val_reg;
    logic                 diag_reg;
    logic [POS_W-1:0]     own_ptr_reg;
    ste_pkg::res_t        res_reg;
    ste_pkg::res_t        out_reg;
    logic                 out_valid_reg;

    // request fields
    logic [IDX_W-1:0] s_col;
    logic [IDX_W-1:0] s_row;
    logic [VAL_W-1:0] s_val;
    logic             req_in;

    assign s_col  = s_tdata[7:0];
    assign s_row  = s_tdata[15:8];
    assign s_val  = s_tdata[79:16];
    assign req_in = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);

    // RAM ports
    logic              tri_we;
    logic [TRI_AW-1:0] tri_waddr;
    logic [TRI_W-1:0]  tri_wdata;
    logic [TRI_AW-1:0] tri_raddr;
    logic [TRI_W-1:0]  tri_rdata;
    logic              tcs_we;
    logic [TCS_AW-1:0] tcs_waddr;
    logic [LC_W-1:0]   tcs_wdata;
    logic [TCS_AW-1:0] tcs_raddr;
    logic [LC_W-1:0]   tcs_rdata;
    logic              cnt_we;
    logic [CNT_AW-1:0] cnt_waddr;
    logic [POS_W-1:0]  cnt_wdata;
    logic [CNT_AW-1:0] cnt_raddr;
    logic [POS_W-1:0]  cnt_rdata;
    logic              ss_we;
    logic [TCS_AW-1:0] ss_waddr;
    logic [POS_W-1:0]  ss_wdata;
    logic [TCS_AW-1:0] ss_raddr;
    logic [POS_W-1:0]  ss_rdata;
    logic              sq_we;
    logic [POS_W-1:0]  sq_waddr;
    logic [SQ_W-1:0]   sq_wdata;
    logic [SQ_W-1:0]   sq_rdata;

    logic             tri_diag;
    logic [IDX_W-1:0] tri_row;
    logic [VAL_W-1:0] tri_val;

    assign tri_diag = tri_rdata[TRI_W-1];
    assign tri_row  = tri_rdata[VAL_W +: IDX_W];
    assign tri_val  = tri_rdata[VAL_W-1:0];

    // load checks, against the state a new session would see
    ste_pkg::status_t err_e;
    logic [LC_W-1:0]  lc_e;
    logic [IDX_W-1:0] lastc_e;
    logic             ld_ok;
    logic             ld_first;
    ste_pkg::status_t ld_code;
    ste_pkg::status_t err_l;
    ste_pkg::status_t err_b;
    logic [LC_W-1:0]  lc_l;
    logic [IDX_W-1:0] lastc_l;
    logic             next_col;

    assign err_e    = ready_reg ? ste_pkg::ST_OK : err_reg;
    assign lc_e     = ready_reg ? '0 : lc_reg;
    assign lastc_e  = ready_reg ? '0 : lastc_reg;
    assign next_col = ({1'b0, s_col} == ((IDX_W+1)'(lastc_e) + 1'b1));

    always_comb
    begin
        ld_ok   = 1'b0;
        ld_code = ste_pkg::ST_MALFORMED;
        priority if (dim_reg > DIM_W'(ste_pkg::MAX_DIM) ||
                     lc_e >= LC_W'(ste_pkg::MAX_TRI_NNZ))
        begin
            ld_code = ste_pkg::ST_OVERFLOW;
        end
        else if (DIM_W'(s_col) >= dim_reg || DIM_W'(s_row) >= dim_reg)
        begin
            ld_ok = 1'b0;
        end
        else if (lc_e == '0)
        begin
            ld_ok = (s_col == '0) && (s_row == s_col);
        end
        else if (s_col == lastc_e)
        begin
            ld_ok = (s_row > s_col);
        end
        else if (next_col)
        begin
            ld_ok = (s_row == s_col);
        end
        else
        begin
            ld_ok = 1'b0;
        end
    end

    assign ld_first = (lc_e == '0) || (s_col != lastc_e);
    assign err_l    = (err_e == ste_pkg::ST_OK && !ld_ok) ? ld_code : err_e;
    assign lc_l     = ld_ok ? lc_e + 1'b1 : lc_e;
    assign lastc_l  = ld_ok ? s_col : lastc_e;

    always_comb
    begin
        err_b = err_l;
        if (err_b == ste_pkg::ST_OK && dim_reg > DIM_W'(ste_pkg::MAX_DIM))
        begin
            err_b = ste_pkg::ST_OVERFLOW;
        end
        if (err_b == ste_pkg::ST_OK &&
            (lc_l == '0 || (DIM_W'(lastc_l) + 1'b1) != dim_reg))
        begin
            err_b = ste_pkg::ST_MALFORMED;
        end
    end

    // scatter column and pass steps
    logic [IDX_W-1:0] col_next;
    logic [POS_W-1:0] pfx_len;
    logic             ent_done;
    logic             col_done;
    logic             adv;
    logic             load_acc;

    assign col_next = tri_diag ? cur_col_reg + 1'b1 : cur_col_reg;
    assign pfx_len  = cnt_rdata + POS_W'(tcs_rdata - tcs_cur_reg);
    assign ent_done = ((idx_reg + 1'b1) == lc_reg);
    assign col_done = ((idx_reg + 1'b1) == LC_W'(n_reg));
    assign adv      = ((DIM_W'(fc_reg) + 1'b1) < built_dim_reg) && (ss_rdata <= fp_reg);
    assign load_acc = (state_reg == S_IDLE) && req_in && !s_tuser;

    // memory port steering
    always_comb
    begin
        tri_we    = load_acc && ld_ok;
        tri_waddr = lc_e[TRI_AW-1:0];
        tri_wdata = {ld_first, s_row, s_val};
        tri_raddr = idx_reg[TRI_AW-1:0];

        tcs_we    = load_acc && ld_ok && ld_first;
        tcs_waddr = TCS_AW'(s_col);
        tcs_wdata = lc_e;
        if (state_reg == S_CLEAR && idx_reg == '0)
        begin
            tcs_we    = 1'b1;
            tcs_waddr = TCS_AW'(n_reg);
            tcs_wdata = lc_reg;
        end
        tcs_raddr = TCS_AW'(idx_reg + 1'b1);

        cnt_we    = 1'b0;
        cnt_waddr = idx_reg[CNT_AW-1:0];
        cnt_wdata = '0;
        cnt_raddr = idx_reg[CNT_AW-1:0];
        ss_we     = 1'b0;
        ss_waddr  = TCS_AW'(idx_reg);
        ss_wdata  = acc_reg;
        sq_we     = 1'b0;
        sq_waddr  = cnt_rdata;
        sq_wdata  = {cur_col_reg, val_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
            end
            S_CNT_TRI:
            begin
                cnt_raddr = CNT_AW'(tri_row);
            end
            S_CNT_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = CNT_AW'(row_reg);
                cnt_wdata = cnt_rdata + 1'b1;
            end
            S_PFX_WR:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = acc_reg;
                ss_we     = 1'b1;
            end
            S_PFX_END:
            begin
                ss_we    = 1'b1;
                ss_waddr = TCS_AW'(n_reg);
            end
            S_SC_TRI:
            begin
                cnt_raddr = CNT_AW'(tri_diag ? col_next : tri_row);
            end
            S_SC_CNT:
            begin
                sq_we     = 1'b1;
                cnt_we    = !diag_reg;
                cnt_waddr = CNT_AW'(row_reg);
                cnt_wdata = cnt_rdata + 1'b1;
            end
            S_SC_OWN:
            begin
                sq_we    = 1'b1;
                sq_waddr = own_ptr_reg;
                sq_wdata = {row_reg, val_reg};
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
        ss_raddr = TCS_AW'(fc_reg) + 1'b1;
    end

    ste_ram #(.WIDTH(TRI_W), .DEPTH(ste_pkg::MAX_TRI_NNZ)) u_tri (
        .clk(clk), .we(tri_we), .waddr(tri_waddr), .wdata(tri_wdata),
        .raddr(tri_raddr), .rdata(tri_rdata)
    );

    ste_ram #(.WIDTH(LC_W), .DEPTH(ste_pkg::MAX_DIM + 1)) u_tcs (
        .clk(clk), .we(tcs_we), .waddr(tcs_waddr), .wdata(tcs_wdata),
        .raddr(tcs_raddr), .rdata(tcs_rdata)
    );

    ste_ram #(.WIDTH(POS_W), .DEPTH(ste_pkg::MAX_DIM)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    ste_ram #(.WIDTH(POS_W), .DEPTH(ste_pkg::MAX_DIM + 1)) u_ss (
        .clk(clk), .we(ss_we), .waddr(ss_waddr), .wdata(ss_wdata),
        .raddr(ss_raddr), .rdata(ss_rdata)
    );

    ste_ram #(.WIDTH(SQ_W), .DEPTH(ste_pkg::SQ_CAP)) u_sq (
        .clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
        .raddr(fp_reg), .rdata(sq_rdata)
    );

    // sequencer, session state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dim_reg       <= '0;
            n_reg         <= '0;
            built_dim_reg <= '0;
            err_reg       <= ste_pkg::ST_OK;
            ready_reg     <= 1'b0;
            lc_reg        <= '0;
            lastc_reg     <= '0;
            fp_reg        <= '0;
            sqc_reg       <= '0;
            fc_reg        <= '0;
            cs_reg        <= '0;
            idx_reg       <= '0;
            acc_reg       <= '0;
            tcs_cur_reg   <= '0;
            cur_col_reg   <= '0;
            row_reg       <= '0;
            val_reg       <= '0;
            diag_reg      <= 1'b0;
            own_ptr_reg   <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dim_reg <= cfg_data;
            end
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_in && !s_tuser)
                    begin
                        err_reg   <= err_l;
                        lc_reg    <= lc_l;
                        lastc_reg <= lastc_l;
                        ready_reg <= 1'b0;
                        if (s_tlast)
                        begin
                            err_reg       <= err_b;
                            ready_reg     <= 1'b1;
                            fp_reg        <= '0;
                            fc_reg        <= '0;
                            cs_reg        <= '0;
                            sqc_reg       <= '0;
                            built_dim_reg <= '0;
                            if (err_b == ste_pkg::ST_OK)
                            begin
                                n_reg     <= dim_reg;
                                idx_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                        end
                    end
                    else if (req_in)
                    begin
                        priority if (!ready_reg)
                        begin
                            res_reg   <= '{status: ste_pkg::ST_EMPTY, default: '0};
                            state_reg <= S_EMIT;
                        end
                        else if (err_reg != ste_pkg::ST_OK)
                        begin
                            res_reg   <= '{status: err_reg, default: '0};
                            state_reg <= S_EMIT;
                        end
                        else if (fp_reg >= sqc_reg)
                        begin
                            res_reg   <= '{status: ste_pkg::ST_EMPTY, default: '0};
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_F_RD;
                        end
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (col_done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD:
                begin
                    state_reg <= S_CNT_TRI;
                end
                S_CNT_TRI:
                begin
                    row_reg <= tri_row;
                    if (!tri_diag)
                    begin
                        state_reg <= S_CNT_WR;
                    end
                    else if (ent_done)
                    begin
                        idx_reg     <= '0;
                        acc_reg     <= '0;
                        tcs_cur_reg <= '0;
                        state_reg   <= S_PFX_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_WR:
                begin
                    if (ent_done)
                    begin
                        idx_reg     <= '0;
                        acc_reg     <= '0;
                        tcs_cur_reg <= '0;
                        state_reg   <= S_PFX_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_PFX_RD:
                begin
                    state_reg <= S_PFX_WR;
                end
                S_PFX_WR:
                begin
                    acc_reg     <= acc_reg + pfx_len;
                    tcs_cur_reg <= tcs_rdata;
                    idx_reg     <= idx_reg + 1'b1;
                    state_reg   <= col_done ? S_PFX_END : S_PFX_RD;
                end
                S_PFX_END:
                begin
                    sqc_reg     <= acc_reg;
                    idx_reg     <= '0;
                    cur_col_reg <= '1;
                    state_reg   <= S_SC_RD;
                end
                S_SC_RD:
                begin
                    state_reg <= S_SC_TRI;
                end
                S_SC_TRI:
                begin
                    row_reg     <= tri_row;
                    val_reg     <= tri_val;
                    diag_reg    <= tri_diag;
                    cur_col_reg <= col_next;
                    state_reg   <= S_SC_CNT;
                end
                S_SC_CNT:
                begin
                    if (diag_reg)
                    begin
                        own_ptr_reg <= cnt_rdata + 1'b1;
                        if (ent_done)
                        begin
                            built_dim_reg <= n_reg;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_SC_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SC_OWN;
                    end
                end
                S_SC_OWN:
                begin
                    own_ptr_reg <= own_ptr_reg + 1'b1;
                    if (ent_done)
                    begin
                        built_dim_reg <= n_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_F_RD:
                begin
                    state_reg <= S_F_DATA;
                end
                S_F_DATA:
                begin
                    // step to the next column once the pointer reaches its start
                    if (adv)
                    begin
                        fc_reg <= fc_reg + 1'b1;
                        cs_reg <= ss_rdata;
                    end
                    res_reg.col       <= adv ? fc_reg + 1'b1 : fc_reg;
                    res_reg.col_start <= adv ? ss_rdata : cs_reg;
                    res_reg.row       <= sq_rdata[VAL_W +: IDX_W];
                    res_reg.value     <= sq_rdata[VAL_W-1:0];
                    res_reg.pos       <= fp_reg;
                    res_reg.last      <= ((fp_reg + 1'b1) == sqc_reg);
                    res_reg.status    <= ste_pkg::ST_OK;
                    fp_reg            <= fp_reg + 1'b1;
                    state_reg         <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold until the output slot is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.col_start, out_reg.pos, out_reg.value,
                       out_reg.row, out_reg.col};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

`include "symmetric_triangle_expand_assert.svh"

    `STE_ASSERT_IMP(a_err_clean, m_tvalid && m_tuser != ste_pkg::ST_OK,
                    m_tdata == '0 && !m_tlast)
    `STE_ASSERT_NXT(a_fetch_busy, s_tvalid && s_tready && s_tuser, !s_tready)
    `STE_ASSERT_IMP(a_ptr_bound,
                    state_reg == S_IDLE && ready_reg && err_reg == ste_pkg::ST_OK,
                    fp_reg <= sqc_reg)
    `STE_ASSERT_IMP(a_fetch_in_range, state_reg == S_F_DATA, fp_reg < sqc_reg)

endmodule

`default_nettype wire
